// ===== rtl/tkpc_pkg.sv =====
// shared types, codes and reset values for the two-key press classifier
`default_nettype none
package tkpc_pkg;

	localparam int CountW   = 8;
	localparam int CfgW     = 8;
	localparam int CfgIdxW  = 3;
	localparam int ActionW  = 3;

	localparam logic [CountW-1:0] CountMax = '1;

	// register reset values
	localparam logic [CfgW-1:0] ShortPressTickRst   = 8'd2;
	localparam logic [CfgW-1:0] ReleaseCheckTickRst = 8'd4;
	localparam logic [CfgW-1:0] LongPressTicksRst   = 8'd30;
	localparam logic [CfgW-1:0] ReleaseHoldTicksRst = 8'd2;

	typedef enum logic [CfgIdxW-1:0] {
		REG_SHORT_PRESS_TICK   = 3'd0,
		REG_RELEASE_CHECK_TICK = 3'd1,
		REG_LONG_PRESS_TICKS   = 3'd2,
		REG_RELEASE_HOLD_TICKS = 3'd3
	} reg_idx_t;

	typedef enum logic [ActionW-1:0] {
		ACT_TICK       = 3'd0,
		ACT_TAKE_HELP  = 3'd1,
		ACT_TAKE_BATT  = 3'd2,
		ACT_ACK_LONG   = 3'd3,
		ACT_DIS_DOUBLE = 3'd4
	} action_t;

	typedef struct packed {
		logic [CfgW-1:0] short_press_tick;
		logic [CfgW-1:0] release_check_tick;
		logic [CfgW-1:0] long_press_ticks;
		logic [CfgW-1:0] release_hold_ticks;
	} cfg_t;

	typedef struct packed {
		logic [CountW-1:0] count;
		logic              held;
		logic              deliver_ok;
		logic              short_latch;
		logic              long_latch;
	} key_state_t;

	typedef struct packed {
		logic [ActionW-1:0] action;
		logic               help_pressed;
		logic               batt_pressed;
		logic               module_on;
	} item_t;

	typedef struct packed {
		logic key_taken;
		logic help_long;
		logic batt_long;
		logic power_down_request;
		logic help_short_pending;
		logic batt_short_pending;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/tkpc_if.sv =====
// valid/ready channel interfaces for input and result words
`default_nettype none
interface tkpc_in_if;
	logic                          valid;
	logic                          ready;
	logic [tkpc_pkg::ActionW-1:0]  action;
	logic                          help_pressed;
	logic                          batt_pressed;
	logic                          module_on;

	modport source (output valid, action, help_pressed, batt_pressed, module_on, input ready);
	modport sink   (input valid, action, help_pressed, batt_pressed, module_on, output ready);
endinterface

interface tkpc_out_if;
	logic valid;
	logic ready;
	logic key_taken;
	logic help_long;
	logic batt_long;
	logic power_down_request;
	logic help_short_pending;
	logic batt_short_pending;

	modport source (output valid, key_taken, help_long, batt_long, power_down_request,
		help_short_pending, batt_short_pending, input ready);
	modport sink   (input valid, key_taken, help_long, batt_long, power_down_request,
		help_short_pending, batt_short_pending, output ready);
endinterface
`default_nettype wire

// ===== rtl/tkpc_key.sv =====
// per-key tick logic: counter, long-press hold, short and long latches
`default_nettype none
module tkpc_key (
	input  wire logic                 pressed,
	input  wire logic                 other_pressed,
	input  wire logic                 gate_long,
	input  wire tkpc_pkg::cfg_t       cfg,
	input  wire tkpc_pkg::key_state_t cur,
	output tkpc_pkg::key_state_t      nxt
);

	logic [tkpc_pkg::CountW-1:0] count_inc;

	// saturating increment
	assign count_inc = (cur.count != tkpc_pkg::CountMax) ? cur.count + 1'b1 : cur.count;

	// long check first, then short, then release check
	always_comb begin
		nxt = cur;
		if (pressed) begin
			if (!cur.held) begin
				nxt.count = count_inc;
				if (count_inc > cfg.long_press_ticks) begin
					nxt.held  = 1'b1;
					nxt.count = '0;
					if (!(gate_long && other_pressed)) begin
						nxt.long_latch = 1'b1;
					end
				end else if (count_inc == cfg.short_press_tick) begin
					nxt.deliver_ok  = 1'b0;
					nxt.short_latch = 1'b1;
				end else if (count_inc == cfg.release_check_tick && !other_pressed) begin
					nxt.deliver_ok = 1'b1;
				end
			end else begin
				nxt.count = '0;
			end
		end else begin
			if (cur.held) begin
				nxt.count = count_inc;
				if (count_inc > cfg.release_hold_ticks) begin
					nxt.held       = 1'b0;
					nxt.count      = '0;
					nxt.deliver_ok = 1'b1;
				end
			end else begin
				nxt.count = '0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/tkpc_core.sv =====
// classifier state registers and the single-pass update for one word
`default_nettype none
module tkpc_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step,
	input  wire tkpc_pkg::item_t item,
	input  wire tkpc_pkg::cfg_t  cfg,
	output tkpc_pkg::result_t    result
);

	tkpc_pkg::key_state_t help_q, batt_q;
	tkpc_pkg::key_state_t help_tick, batt_tick;
	tkpc_pkg::key_state_t help_nxt, batt_nxt;
	logic double_dis_q, double_dis_nxt;
	logic pwr_down_q, pwr_down_nxt;
	logic taken;

	// tick update of each key
	tkpc_key u_help (
		.pressed       (item.help_pressed),
		.other_pressed (item.batt_pressed),
		.gate_long     (1'b1),
		.cfg           (cfg),
		.cur           (help_q),
		.nxt           (help_tick)
	);

	tkpc_key u_batt (
		.pressed       (item.batt_pressed),
		.other_pressed (item.help_pressed),
		.gate_long     (1'b0),
		.cfg           (cfg),
		.cur           (batt_q),
		.nxt           (batt_tick)
	);

	// action decode and next state
	always_comb begin
		help_nxt       = help_q;
		batt_nxt       = batt_q;
		double_dis_nxt = double_dis_q;
		pwr_down_nxt   = pwr_down_q;
		taken          = 1'b0;
		case (tkpc_pkg::action_t'(item.action))
			tkpc_pkg::ACT_TICK: begin
				help_nxt = help_tick;
				batt_nxt = batt_tick;
				if (help_tick.held && batt_tick.held) begin
					if (!batt_tick.deliver_ok) batt_nxt.short_latch = 1'b0;
					if (!help_tick.deliver_ok) help_nxt.short_latch = 1'b0;
					if (!double_dis_q && item.module_on) pwr_down_nxt = 1'b1;
				end
				if (help_tick.deliver_ok && batt_tick.deliver_ok) begin
					double_dis_nxt = 1'b0;
				end
			end
			tkpc_pkg::ACT_TAKE_HELP: begin
				if (help_q.short_latch && help_q.deliver_ok) begin
					taken                = 1'b1;
					help_nxt.short_latch = 1'b0;
				end
			end
			tkpc_pkg::ACT_TAKE_BATT: begin
				if (batt_q.short_latch && batt_q.deliver_ok) begin
					taken                = 1'b1;
					batt_nxt.short_latch = 1'b0;
				end
			end
			tkpc_pkg::ACT_ACK_LONG: begin
				help_nxt.long_latch = 1'b0;
				batt_nxt.long_latch = 1'b0;
				pwr_down_nxt        = 1'b0;
			end
			tkpc_pkg::ACT_DIS_DOUBLE: begin
				double_dis_nxt = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			help_q       <= '{count: '0, held: 1'b0, deliver_ok: 1'b1,
				short_latch: 1'b0, long_latch: 1'b0};
			batt_q       <= '{count: '0, held: 1'b0, deliver_ok: 1'b1,
				short_latch: 1'b0, long_latch: 1'b0};
			double_dis_q <= 1'b0;
			pwr_down_q   <= 1'b0;
		end else if (step) begin
			help_q       <= help_nxt;
			batt_q       <= batt_nxt;
			double_dis_q <= double_dis_nxt;
			pwr_down_q   <= pwr_down_nxt;
		end
	end

	// result shows state after the action
	assign result = '{
		key_taken:          taken,
		help_long:          help_nxt.long_latch,
		batt_long:          batt_nxt.long_latch,
		power_down_request: pwr_down_nxt,
		help_short_pending: help_nxt.short_latch,
		batt_short_pending: batt_nxt.short_latch
	};

endmodule
`default_nettype wire

// ===== rtl/two_key_press_classifier.sv =====
// top level of the two-key press classifier: input stage, core, result register
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        action, help_pressed, batt_pressed, module_on
//   out_ch   out  valid/ready        key_taken, help_long, batt_long,
//                                    power_down_request, help/batt_short_pending
//   cfg      in   cfg_we (no stall)  cfg_index, cfg_wdata
//
// A word passes from acceptance to result via the input register, then the
// state update feeding the result register. One word per cycle is sustained
// while out_ch.ready holds. A stalled result register holds the input stage,
// which then drops in_ch.ready only when it is occupied. Reset clears all
// control state and loads the register defaults; no clearing pass is needed.
`default_nettype none
module two_key_press_classifier (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	tkpc_in_if.sink                            in_ch,
	tkpc_out_if.source                         out_ch,
	input  wire logic                          cfg_we,
	input  wire logic [tkpc_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [tkpc_pkg::CfgW-1:0]     cfg_wdata
);

	tkpc_pkg::cfg_t    cfg_q;
	tkpc_pkg::item_t   item_s1;
	tkpc_pkg::result_t result_comb;
	tkpc_pkg::result_t result_q;
	logic valid_s1;
	logic out_valid_q;
	logic advance;
	logic in_fire;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_press_tick   <= tkpc_pkg::ShortPressTickRst;
			cfg_q.release_check_tick <= tkpc_pkg::ReleaseCheckTickRst;
			cfg_q.long_press_ticks   <= tkpc_pkg::LongPressTicksRst;
			cfg_q.release_hold_ticks <= tkpc_pkg::ReleaseHoldTicksRst;
		end else if (cfg_we) begin
			case (tkpc_pkg::reg_idx_t'(cfg_index))
				tkpc_pkg::REG_SHORT_PRESS_TICK:   cfg_q.short_press_tick   <= cfg_wdata;
				tkpc_pkg::REG_RELEASE_CHECK_TICK: cfg_q.release_check_tick <= cfg_wdata;
				tkpc_pkg::REG_LONG_PRESS_TICKS:   cfg_q.long_press_ticks   <= cfg_wdata;
				tkpc_pkg::REG_RELEASE_HOLD_TICKS: cfg_q.release_hold_ticks <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// handshake control
	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;
	assign in_fire     = in_ch.valid && in_ch.ready;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= '{action: in_ch.action, help_pressed: in_ch.help_pressed,
				batt_pressed: in_ch.batt_pressed, module_on: in_ch.module_on};
		end
	end

	// state update
	tkpc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result_comb)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_comb;
		end
	end

	assign out_ch.valid              = out_valid_q;
	assign out_ch.key_taken          = result_q.key_taken;
	assign out_ch.help_long          = result_q.help_long;
	assign out_ch.batt_long          = result_q.batt_long;
	assign out_ch.power_down_request = result_q.power_down_request;
	assign out_ch.help_short_pending = result_q.help_short_pending;
	assign out_ch.batt_short_pending = result_q.batt_short_pending;

	// an empty input stage always takes a word
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ch.ready)
		else $error("input stage empty but not ready");

	// an accepted word reaches the input stage
	a_accept_loads_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> valid_s1)
		else $error("accepted word lost before input stage");

	// a processed word always shows up as a result
	a_advance_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed word did not reach result register");

endmodule
`default_nettype wire
